// ===== design/source_text_tokenizer_unit_assert.svh =====
// Assertion macros for the tokenizer modules.
// Depends on nothing; included by modules that carry assertions.
`ifndef SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define STT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stt_pkg.sv =====
// Shared types, codes and lookup functions for the source text tokenizer.
// Depends on nothing.
package stt_pkg;

    localparam int WINDOW_BYTES = 8;
    localparam int OFFSET_WIDTH = 24;
    localparam int COUNT_WIDTH  = 16;
    localparam int LEN_WIDTH    = $clog2(WINDOW_BYTES) + 1;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX  = '1;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_IDENT     = 3'd1,
        MODE_NUMBER    = 3'd2,
        MODE_STRING    = 3'd3,
        MODE_DIRECTIVE = 3'd4,
        MODE_OPERATOR  = 3'd5
    } scan_mode_t;

    localparam logic [5:0] TK_EOF     = 6'd0;
    localparam logic [5:0] TK_INVALID = 6'd1;
    localparam logic [5:0] TK_IDENT   = 6'd2;
    localparam logic [5:0] TK_STRING  = 6'd3;
    localparam logic [5:0] TK_NUMBER  = 6'd4;
    localparam logic [5:0] TK_INCLUDE = 6'd6;
    localparam logic [5:0] TK_DEFINE  = 6'd7;
    localparam logic [5:0] TK_FN      = 6'd54;
    localparam logic [5:0] TK_PUB     = 6'd55;
    localparam logic [5:0] TK_CONST   = 6'd56;
    localparam logic [5:0] TK_VAR     = 6'd57;
    localparam logic [5:0] TK_RETURN  = 6'd58;
    localparam logic [5:0] TK_IF      = 6'd59;
    localparam logic [5:0] TK_FOR     = 6'd60;
    localparam logic [5:0] TK_WHILE   = 6'd61;

    typedef logic [WINDOW_BYTES*8-1:0] window_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic [5:0]              token_kind;
        logic [COUNT_WIDTH-1:0]  token_number;
        logic [OFFSET_WIDTH-1:0] start_offset;
        logic [COUNT_WIDTH-1:0]  token_length;
        logic [COUNT_WIDTH-1:0]  line_number;
        logic [COUNT_WIDTH-1:0]  column_number;
        logic                    last;
    } out_item_t;

    // Token descriptor from the scanner, without sequence number.
    typedef struct packed {
        logic [5:0]              token_kind;
        logic [OFFSET_WIDTH-1:0] start_offset;
        logic [COUNT_WIDTH-1:0]  token_length;
        logic [COUNT_WIDTH-1:0]  line_number;
        logic [COUNT_WIDTH-1:0]  column_number;
        logic                    last;
    } tok_t;

    // One queue entry: up to two tokens caused by one input item.
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } tok_pair_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] lead_kind(input logic [7:0] p);
        case (p)
            8'h3D:   return 6'd8;
            8'h2B:   return 6'd10;
            8'h2D:   return 6'd13;
            8'h2A:   return 6'd16;
            8'h2F:   return 6'd21;
            8'h3C:   return 6'd48;
            8'h3E:   return 6'd49;
            8'h7C:   return 6'd18;
            8'h2E:   return 6'd37;
            default: return TK_INVALID;
        endcase
    endfunction

    // Zero means the pair is not an operator.
    function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
        case (p)
            8'h3D:   return (c == 8'h3D) ? 6'd9 : 6'd0;
            8'h2B:   return (c == 8'h2B) ? 6'd11 : (c == 8'h3D) ? 6'd12 : 6'd0;
            8'h2D:   return (c == 8'h2D) ? 6'd14 : (c == 8'h3D) ? 6'd15 :
                            (c == 8'h3E) ? 6'd24 : 6'd0;
            8'h2A:   return (c == 8'h3D) ? 6'd17 : 6'd0;
            8'h2F:   return (c == 8'h2F) ? 6'd23 : (c == 8'h3D) ? 6'd22 : 6'd0;
            8'h3C:   return (c == 8'h3D) ? 6'd50 : (c == 8'h3C) ? 6'd53 : 6'd0;
            8'h3E:   return (c == 8'h3D) ? 6'd51 : (c == 8'h3E) ? 6'd52 : 6'd0;
            8'h7C:   return (c == 8'h7C) ? 6'd19 : 6'd0;
            8'h2E:   return (c == 8'h2E) ? 6'd38 : 6'd0;
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            8'h28:   return 6'd46;
            8'h29:   return 6'd47;
            8'h7B:   return 6'd42;
            8'h7D:   return 6'd43;
            8'h5B:   return 6'd44;
            8'h5D:   return 6'd45;
            8'h3B:   return 6'd41;
            8'h26:   return 6'd35;
            8'h7E:   return 6'd20;
            8'h2C:   return 6'd29;
            8'h3F:   return 6'd33;
            8'h3A:   return 6'd26;
            8'h5E:   return 6'd39;
            8'h21:   return 6'd30;
            default: return TK_INVALID;
        endcase
    endfunction

    // Word packed first byte lowest, zero padded.
    function automatic window_t word_bits(input string s);
        window_t w;
        w = '0;
        for (int i = 0; i < s.len(); i++) begin
            w[i*8 +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic logic [5:0] ident_kind(input window_t w,
                                              input logic [COUNT_WIDTH-1:0] len);
        logic [5:0] k;
        k = TK_IDENT;
        if (len == COUNT_WIDTH'(2) && w == word_bits("if"))     k = TK_IF;
        if (len == COUNT_WIDTH'(3) && w == word_bits("pub"))    k = TK_PUB;
        if (len == COUNT_WIDTH'(2) && w == word_bits("fn"))     k = TK_FN;
        if (len == COUNT_WIDTH'(3) && w == word_bits("for"))    k = TK_FOR;
        if (len == COUNT_WIDTH'(5) && w == word_bits("const"))  k = TK_CONST;
        if (len == COUNT_WIDTH'(3) && w == word_bits("var"))    k = TK_VAR;
        if (len == COUNT_WIDTH'(5) && w == word_bits("while"))  k = TK_WHILE;
        if (len == COUNT_WIDTH'(6) && w == word_bits("return")) k = TK_RETURN;
        return k;
    endfunction

    function automatic logic [5:0] directive_kind(input window_t w,
                                                  input logic [COUNT_WIDTH-1:0] len);
        logic [5:0] k;
        k = TK_INVALID;
        if (len == COUNT_WIDTH'(7) && w == word_bits("#define"))  k = TK_DEFINE;
        if (len == COUNT_WIDTH'(8) && w == word_bits("#include")) k = TK_INCLUDE;
        return k;
    endfunction

endpackage

// ===== design/stt_scanner.sv =====
// Front end: accepts bytes, tracks scan mode and position, classifies tokens.
// Depends on stt_pkg.
module stt_scanner (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  stt_pkg::in_item_t  in_item,
    output logic               tok_valid,
    output stt_pkg::tok_pair_t tok_pair
);

    localparam int OW = stt_pkg::OFFSET_WIDTH;
    localparam int CW = stt_pkg::COUNT_WIDTH;
    localparam int WB = stt_pkg::WINDOW_BYTES;

    stt_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0]          pend_reg, pend_next;
    stt_pkg::window_t    win_reg, win_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [OW-1:0]       tstart_reg, tstart_next;
    logic [CW-1:0]       tline_reg, tline_next;
    logic [CW-1:0]       tcol_reg, tcol_next;
    logic [OW-1:0]       off_reg, off_next;
    logic [CW-1:0]       line_reg, line_next;
    logic [CW-1:0]       col_reg, col_next;

    logic [7:0]          c;
    logic [5:0]          open_kind;
    logic [5:0]          pk;
    logic                fresh;
    stt_pkg::tok_pair_t  pr;
    stt_pkg::tok_t       t_open;
    stt_pkg::tok_t       t_new;
    logic [OW-1:0]       off_adv;
    logic [CW-1:0]       line_adv, col_adv;

    assign c = in_item.char_code;
    assign pk = stt_pkg::pair_kind(pend_reg, c);

    always_comb begin
        unique case (mode_reg)
            stt_pkg::MODE_IDENT:     open_kind = stt_pkg::ident_kind(win_reg, len_reg);
            stt_pkg::MODE_NUMBER:    open_kind = stt_pkg::TK_NUMBER;
            stt_pkg::MODE_DIRECTIVE: open_kind = stt_pkg::directive_kind(win_reg, len_reg);
            stt_pkg::MODE_OPERATOR:  open_kind = stt_pkg::lead_kind(pend_reg);
            default:                 open_kind = stt_pkg::TK_INVALID;
        endcase
    end

    // Position after consuming c
    always_comb begin
        off_adv  = (off_reg == stt_pkg::OFFSET_MAX) ? off_reg : off_reg + OW'(1);
        line_adv = line_reg;
        col_adv  = (col_reg == stt_pkg::COUNT_MAX) ? col_reg : col_reg + CW'(1);
        if (c == 8'h0A) begin
            line_adv = (line_reg == stt_pkg::COUNT_MAX) ? line_reg : line_reg + CW'(1);
            col_adv  = CW'(1);
        end
    end

    always_comb begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        win_next    = win_reg;
        len_next    = len_reg;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        pr          = '0;
        fresh       = 1'b0;

        t_open.token_kind    = open_kind;
        t_open.start_offset  = tstart_reg;
        t_open.token_length  = len_reg;
        t_open.line_number   = tline_reg;
        t_open.column_number = tcol_reg;
        t_open.last          = 1'b0;

        t_new.token_kind    = stt_pkg::single_kind(c);
        t_new.start_offset  = off_reg;
        t_new.token_length  = CW'(1);
        t_new.line_number   = line_reg;
        t_new.column_number = col_reg;
        t_new.last          = 1'b1;

        if (in_item.kind) begin
            t_new.token_kind   = stt_pkg::TK_EOF;
            t_new.token_length = '0;
            if (mode_reg != stt_pkg::MODE_IDLE) begin
                if (mode_reg == stt_pkg::MODE_STRING) t_open.token_kind = stt_pkg::TK_INVALID;
                pr.count  = 2'd2;
                pr.first  = t_open;
                pr.second = t_new;
            end else begin
                pr.count = 2'd1;
                pr.first = t_new;
            end
            mode_next = stt_pkg::MODE_IDLE;
            pend_next = '0;
            win_next  = '0;
            len_next  = '0;
            off_next  = '0;
            line_next = CW'(1);
            col_next  = CW'(1);
        end else begin
            unique case (mode_reg)
                stt_pkg::MODE_IDENT, stt_pkg::MODE_DIRECTIVE, stt_pkg::MODE_NUMBER: begin
                    if (stt_pkg::is_digit(c) ||
                        (mode_reg != stt_pkg::MODE_NUMBER && stt_pkg::is_alpha(c))) begin
                        if (len_reg < CW'(WB)) win_next[len_reg[stt_pkg::LEN_WIDTH-2:0]*8 +: 8] = c;
                        len_next = (len_reg == stt_pkg::COUNT_MAX) ? len_reg : len_reg + CW'(1);
                        off_next = off_adv;
                        line_next = line_adv;
                        col_next = col_adv;
                    end else begin
                        pr.count = 2'd1;
                        pr.first = t_open;
                        mode_next = stt_pkg::MODE_IDLE;
                        pend_next = '0;
                        fresh = 1'b1;
                    end
                end
                stt_pkg::MODE_STRING: begin
                    len_next = (len_reg == stt_pkg::COUNT_MAX) ? len_reg : len_reg + CW'(1);
                    off_next = off_adv;
                    line_next = line_adv;
                    col_next = col_adv;
                    if (c == 8'h22) begin
                        pr.count = 2'd1;
                        pr.first = t_open;
                        pr.first.token_kind = stt_pkg::TK_STRING;
                        pr.first.token_length = len_next;
                        pr.first.last = 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                        pend_next = '0;
                    end
                end
                stt_pkg::MODE_OPERATOR: begin
                    if (pk != 6'd0) begin
                        len_next = (len_reg == stt_pkg::COUNT_MAX) ? len_reg : len_reg + CW'(1);
                        off_next = off_adv;
                        line_next = line_adv;
                        col_next = col_adv;
                        pr.count = 2'd1;
                        pr.first = t_open;
                        pr.first.token_kind = pk;
                        pr.first.token_length = len_next;
                        pr.first.last = 1'b1;
                        mode_next = stt_pkg::MODE_IDLE;
                        pend_next = '0;
                    end else begin
                        pr.count = 2'd1;
                        pr.first = t_open;
                        mode_next = stt_pkg::MODE_IDLE;
                        pend_next = '0;
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase

            if (fresh) begin
                off_next  = off_adv;
                line_next = line_adv;
                col_next  = col_adv;
                if (c == 8'h20 || c == 8'h09 || c == 8'h0A) begin
                    if (pr.count != 2'd0) pr.first.last = 1'b1;
                end else begin
                    tstart_next = off_reg;
                    tline_next  = line_reg;
                    tcol_next   = col_reg;
                    win_next    = '0;
                    win_next[7:0] = c;
                    len_next    = CW'(1);
                    if (stt_pkg::is_alpha(c)) mode_next = stt_pkg::MODE_IDENT;
                    else if (stt_pkg::is_digit(c)) mode_next = stt_pkg::MODE_NUMBER;
                    else if (c == 8'h22) mode_next = stt_pkg::MODE_STRING;
                    else if (c == 8'h23) mode_next = stt_pkg::MODE_DIRECTIVE;
                    else if (stt_pkg::lead_kind(c) != stt_pkg::TK_INVALID) begin
                        mode_next = stt_pkg::MODE_OPERATOR;
                        pend_next = c;
                    end else begin
                        if (pr.count == 2'd0) begin
                            pr.count = 2'd1;
                            pr.first = t_new;
                        end else begin
                            pr.count  = 2'd2;
                            pr.second = t_new;
                        end
                    end
                    if (pr.count == 2'd1 && mode_next != stt_pkg::MODE_IDLE)
                        pr.first.last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            pend_reg   <= '0;
            win_reg    <= '0;
            len_reg    <= '0;
            tstart_reg <= '0;
            tline_reg  <= CW'(1);
            tcol_reg   <= CW'(1);
            off_reg    <= '0;
            line_reg   <= CW'(1);
            col_reg    <= CW'(1);
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            win_reg    <= win_next;
            len_reg    <= len_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            off_reg    <= off_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
        end
    end

    assign tok_valid = in_fire && (pr.count != 2'd0);
    assign tok_pair  = pr;

endmodule

// ===== design/stt_emitter.sv =====
// Back end: queue of token pairs, numbering and output register.
// Depends on stt_pkg and the assertion header.
`include "source_text_tokenizer_unit_assert.svh"
module stt_emitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tok_valid,
    input  stt_pkg::tok_pair_t  tok_pair,
    output logic                q_has_room,
    output logic                m_valid,
    input  logic                m_ready,
    output stt_pkg::out_item_t  m_data
);

    localparam int CW = stt_pkg::COUNT_WIDTH;

    stt_pkg::tok_pair_t  q_mem [4];
    logic [1:0]          wp_reg, rp_reg;
    logic [2:0]          cnt_reg;
    logic                sub_reg;
    logic [CW-1:0]       num_reg;
    logic                ov_reg;
    stt_pkg::out_item_t  od_reg;
    stt_pkg::tok_pair_t  head;
    stt_pkg::tok_t       cur;
    logic                pop_tok, pop_entry, push;

    assign head       = q_mem[rp_reg];
    assign cur        = sub_reg ? head.second : head.first;
    assign q_has_room = cnt_reg != 3'd4;
    assign push       = tok_valid;
    assign pop_tok    = (cnt_reg != 3'd0) && (!ov_reg || m_ready);
    assign pop_entry  = pop_tok && (sub_reg || head.count == 2'd1);

    always_ff @(posedge aclk) begin
        if (push) q_mem[wp_reg] <= tok_pair;
        if (pop_tok) begin
            od_reg.token_kind    <= cur.token_kind;
            od_reg.token_number  <= num_reg;
            od_reg.start_offset  <= cur.start_offset;
            od_reg.token_length  <= cur.token_length;
            od_reg.line_number   <= cur.line_number;
            od_reg.column_number <= cur.column_number;
            od_reg.last          <= cur.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            sub_reg <= 1'b0;
            num_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop_entry) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop_entry);
            if (pop_tok) begin
                sub_reg <= !pop_entry;
                num_reg <= num_reg + CW'(1);
            end
            if (pop_tok) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = od_reg;

    `STT_ASSERT_IMPLY(a_no_overflow, aclk, aresetn, push, cnt_reg <= 3'd3 || pop_entry, "queue overflow")
    `STT_ASSERT_IMPLY(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= 3'd4, "queue count out of range")
    `STT_ASSERT_NEXT(a_num_step, aclk, aresetn, pop_tok, num_reg == $past(num_reg) + CW'(1), "numbering skipped")
    `STT_ASSERT_IMPLY(a_sub_only_pair, aclk, aresetn, sub_reg, cnt_reg != 3'd0 && head.count == 2'd2, "second slot without pair")

endmodule

// ===== design/source_text_tokenizer_unit.sv =====
// Top level of the streaming source text tokenizer.
// Depends on stt_pkg, stt_scanner and stt_emitter.
//
// Usage: feed one source byte per transaction on s_ (kind 0), or an end-of-input
// mark (kind 1). Each token leaves on m_ as one transaction carrying kind, sequence
// number, start offset, length, line and column; last marks the final token that
// one input transaction caused. One input causes zero, one or two tokens.
// m_valid rises once the token that an accepted byte ends has passed the token
// queue and then the output register, when the queue and output register are empty.
// Throughput: one input per cycle while m_ready stays high, as long as each byte
// makes at most one token; a byte that makes two tokens sends both through the
// single output register, which drains the token queue one token per cycle.
// The scanner sits in front of a four-entry queue of token pairs; s_ready drops
// only when that queue cannot take another entry, so a stalled receiver backs
// up the queue first and then stops input.
// Reset (aresetn low, synchronous) returns scan mode, position counters and the
// token counter to their start values and empties the queue.
module source_text_tokenizer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stt_pkg::out_item_t m_data
);

    logic               room;
    logic               tok_valid;
    stt_pkg::tok_pair_t tok_pair;

    // Queue admits at most one entry per accepted transaction, so room gates input.
    assign s_ready = room;

    stt_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .in_item   (s_data),
        .tok_valid (tok_valid),
        .tok_pair  (tok_pair)
    );

    stt_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tok_valid  (tok_valid),
        .tok_pair   (tok_pair),
        .q_has_room (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
